/* rtl/aps_pkg.sv */
// Shared constants, types and the arctangent table of the pitch smoother.
`timescale 1ns / 1ps
`default_nettype none
package aps_pkg;

  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int DEF_CORDIC_STEPS = 16;

  localparam int ACC_W     = 25;  // CORDIC angle accumulator, Q9.16 degrees
  localparam int PITCH_W   = 24;  // clamped pitch and running average, Q8.16
  localparam int DIFF_W    = 25;  // pitch minus average
  localparam int OUT_W     = 16;  // Q8.8 result fields
  localparam int WEIGHT_W  = 16;  // Q0.16 smoothing weight
  localparam int ARC_IDX_W = 5;   // index into the arctangent table
  localparam int FRAC_SHIFT = 8;  // Q8.16 to Q8.8
  localparam int VEC_GUARD = 11;  // extra bits of the CORDIC vector registers

  localparam logic signed [ACC_W-1:0]  NINETY_Q16 = 25'sd5898240;
  localparam logic signed [OUT_W-1:0]  NINETY_Q8  = 16'sd23040;
  localparam logic [WEIGHT_W-1:0]      WEIGHT_RESET = 16'd6554;

  // word index of the configuration registers
  localparam logic REG_SMOOTHING_WEIGHT = 1'b0;

  typedef struct packed {
    logic                       done;
    logic signed [PITCH_W-1:0]  angle;
  } cordic_res_t;

  // atan(2^-i) in degrees, Q8.16, rounded
  function automatic logic [PITCH_W-1:0] arc_of(input logic [ARC_IDX_W-1:0] idx);
    logic [PITCH_W-1:0] v;
    case (idx)
      5'd0:  v = 24'd2949120;
      5'd1:  v = 24'd1740967;
      5'd2:  v = 24'd919879;
      5'd3:  v = 24'd466945;
      5'd4:  v = 24'd234379;
      5'd5:  v = 24'd117304;
      5'd6:  v = 24'd58666;
      5'd7:  v = 24'd29335;
      5'd8:  v = 24'd14668;
      5'd9:  v = 24'd7334;
      5'd10: v = 24'd3667;
      5'd11: v = 24'd1833;
      5'd12: v = 24'd917;
      5'd13: v = 24'd458;
      5'd14: v = 24'd229;
      5'd15: v = 24'd115;
      5'd16: v = 24'd57;
      5'd17: v = 24'd29;
      5'd18: v = 24'd14;
      5'd19: v = 24'd7;
      5'd20: v = 24'd4;
      5'd21: v = 24'd2;
      5'd22: v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/aps_isqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle, rounded down.
`timescale 1ns / 1ps
`default_nettype none
module aps_isqrt import aps_pkg::*; #(
  parameter int ROOT_W = DEF_SAMPLE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic                       done,
  output logic [ROOT_W-1:0]          root
);

  localparam int RemW = ROOT_W + 2;
  localparam int CntW = $clog2(ROOT_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CntW-1:0]      cnt_r;
  logic [2*ROOT_W-1:0]  rad_r;
  logic [RemW-1:0]      rem_r;
  logic [ROOT_W-1:0]    root_r;

  logic [RemW+1:0]      rem_sh;
  logic [RemW+1:0]      trial;
  logic                 fits;
  logic [RemW+1:0]      rem_diff;

  always_comb begin
    rem_sh   = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    fits     = (rem_sh >= trial);
    rem_diff = fits ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[2*ROOT_W-3:0], 2'b00};
      rem_r  <= rem_diff[RemW-1:0];
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

/* rtl/aps_cordic.sv */
// Iterative CORDIC vectoring unit: one rotation per cycle, then angle clamp.
`timescale 1ns / 1ps
`default_nettype none
module aps_cordic import aps_pkg::*; #(
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [SAMPLE_BITS-1:0]        mag,
  input  wire logic signed [SAMPLE_BITS-1:0] ax,
  output cordic_res_t                        res
);

  localparam int VecW  = SAMPLE_BITS + VEC_GUARD;
  localparam int StepW = $clog2(CORDIC_STEPS);
  localparam int PadW  = VecW - SAMPLE_BITS - FRAC_SHIFT;

  logic                      busy_r;
  logic                      fin_r;
  logic                      done_r;
  logic                      zero_r;
  logic [StepW-1:0]          cnt_r;
  logic signed [VecW-1:0]    x_r;
  logic signed [VecW-1:0]    y_r;
  logic signed [ACC_W-1:0]   z_r;
  logic signed [PITCH_W-1:0] angle_r;

  logic signed [VecW-1:0]    dx;
  logic signed [VecW-1:0]    dy;
  logic signed [ACC_W-1:0]   arc;
  logic signed [ACC_W-1:0]   z_clamp;

  always_comb begin
    dx  = y_r >>> cnt_r;
    dy  = x_r >>> cnt_r;
    arc = signed'(ACC_W'(arc_of(ARC_IDX_W'(cnt_r))));
    if (z_r > NINETY_Q16) begin
      z_clamp = NINETY_Q16;
    end else if (z_r < -NINETY_Q16) begin
      z_clamp = -NINETY_Q16;
    end else begin
      z_clamp = z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r  <= 1'b0;
      done_r <= fin_r;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == StepW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= signed'({{PadW{1'b0}}, mag, {FRAC_SHIFT{1'b0}}});
      y_r    <= {{PadW{ax[SAMPLE_BITS-1]}}, ax, {FRAC_SHIFT{1'b0}}};
      z_r    <= '0;
      zero_r <= (ax == '0);
    end else if (busy_r) begin
      // rotate toward the x axis by the sign of y
      if (!y_r[VecW-1]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + arc;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - arc;
      end
    end
    if (fin_r) begin
      // no pitch-axis component means level, whatever the iterations gave
      angle_r <= zero_r ? '0 : z_clamp[PITCH_W-1:0];
    end
  end

  assign res.done  = done_r;
  assign res.angle = angle_r;

endmodule
`default_nettype wire

/* rtl/accel_pitch_smoother_core.sv */
// Top level of the accelerometer pitch smoother: sequencer, shared multiplier, EMA, APB.
// Per sample: squaring of y and z on the shared multiplier, one bit per cycle in the
// square-root unit, one rotation per cycle in the CORDIC unit, then difference, weight
// multiply, average update and min/max. in_ready is high only while the sequencer is
// idle; a finished result sits in the output register and the next sample is taken
// meanwhile. The pitch is atan2(x, sqrt(y^2+z^2)) in degrees; all three outputs are
// signed Q8.8. smoothing_weight (Q0.16, reset 0.1) lies at byte address 0.
`timescale 1ns / 1ps
`default_nettype none
module accel_pitch_smoother_core import aps_pkg::*; #(
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  wire logic signed [SAMPLE_BITS-1:0] in_accel_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [OUT_W-1:0]            out_smoothed_pitch,
  output logic signed [OUT_W-1:0]            out_lowest_pitch,
  output logic signed [OUT_W-1:0]            out_highest_pitch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int MulW = (SAMPLE_BITS > DIFF_W) ? SAMPLE_BITS : DIFF_W;
  localparam int SqW  = 2 * SAMPLE_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQY  = 4'd1;
  localparam logic [3:0] ST_SQZ  = 4'd2;
  localparam logic [3:0] ST_SQS  = 4'd3;
  localparam logic [3:0] ST_SQRT = 4'd4;
  localparam logic [3:0] ST_CORD = 4'd5;
  localparam logic [3:0] ST_MULE = 4'd6;
  localparam logic [3:0] ST_AVG  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]                  state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] ax_r, ay_r, az_r;
  logic [SqW-1:0]              acc_r;
  logic signed [2*MulW-1:0]    prod_r;
  logic signed [DIFF_W-1:0]    diff_r;
  logic signed [PITCH_W-1:0]   avg_r;
  logic signed [OUT_W-1:0]     floor_r, ceil_r, smooth_r;
  logic                        out_valid_r;
  logic [WEIGHT_W-1:0]         weight_r;

  logic signed [MulW-1:0]      mul_a, mul_b;
  logic signed [2*MulW-1:0]    mul_p;
  logic                        sqrt_start, sqrt_done;
  logic [SqW-1:0]              radicand;
  logic [SAMPLE_BITS-1:0]      root;
  logic                        cordic_start;
  cordic_res_t                 cordic_res;
  logic signed [DIFF_W-1:0]    avg_sum;
  logic signed [OUT_W-1:0]     s_val;
  logic                        out_free;
  logic                        cfg_wr;

  // ---------------- configuration port ----------------
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == REG_SMOOTHING_WEIGHT && paddr[1:0] == 2'b00) begin
      prdata = {{(32 - WEIGHT_W){1'b0}}, weight_r};
    end else if (paddr[2] == REG_SMOOTHING_WEIGHT) begin
      prdata = {{(32 - WEIGHT_W){1'b0}}, weight_r};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_wr && paddr[2] == REG_SMOOTHING_WEIGHT) begin
      weight_r <= pwdata[WEIGHT_W-1:0];
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    case (state_r)
      ST_SQY: begin
        mul_a = MulW'(ay_r);
        mul_b = MulW'(ay_r);
      end
      ST_SQZ: begin
        mul_a = MulW'(az_r);
        mul_b = MulW'(az_r);
      end
      default: begin
        mul_a = signed'(MulW'(weight_r));
        mul_b = MulW'(diff_r);
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // ---------------- iterative units ----------------
  assign sqrt_start = (state_r == ST_SQS);
  assign radicand   = acc_r + prod_r[SqW-1:0];

  aps_isqrt #(
    .ROOT_W(SAMPLE_BITS)
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .radicand(radicand),
    .done    (sqrt_done),
    .root    (root)
  );

  assign cordic_start = (state_r == ST_SQRT) && sqrt_done;

  aps_cordic #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cordic_start),
    .mag  (root),
    .ax   (ax_r),
    .res  (cordic_res)
  );

  // ---------------- sequencer ----------------
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  // avg + floor(w * (pitch - avg) / 2^16) equals the weighted blend, floored
  assign avg_sum  = DIFF_W'(avg_r) + signed'(prod_r[WEIGHT_W +: DIFF_W]);
  assign s_val    = avg_r[PITCH_W-1 -: OUT_W];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_SQZ;
      ST_SQZ:  state_nxt = ST_SQS;
      ST_SQS:  state_nxt = ST_SQRT;
      ST_SQRT: if (sqrt_done) state_nxt = ST_CORD;
      ST_CORD: if (cordic_res.done) state_nxt = ST_MULE;
      ST_MULE: state_nxt = ST_AVG;
      ST_AVG:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      avg_r       <= '0;
      floor_r     <= NINETY_Q8;
      ceil_r      <= -NINETY_Q8;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_AVG) begin
        avg_r <= avg_sum[PITCH_W-1:0];
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        if (s_val < floor_r) floor_r <= s_val;
        if (s_val > ceil_r)  ceil_r  <= s_val;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
    end
    if (state_r == ST_SQY || state_r == ST_SQZ || state_r == ST_MULE) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_SQZ) begin
      acc_r <= prod_r[SqW-1:0];
    end
    if (state_r == ST_CORD && cordic_res.done) begin
      diff_r <= DIFF_W'(cordic_res.angle) - DIFF_W'(avg_r);
    end
    if (state_r == ST_FIN && out_free) begin
      smooth_r <= s_val;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_pitch = smooth_r;
  assign out_lowest_pitch   = floor_r;
  assign out_highest_pitch  = ceil_r;

  // ---------------- assertions ----------------
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (floor_r <= smooth_r) && (smooth_r <= ceil_r))
    else $error("smoothed pitch outside running min/max");

  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ACC_W'(avg_r) <= NINETY_Q16) && (ACC_W'(avg_r) >= -NINETY_Q16))
    else $error("average pitch beyond ninety degrees");

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == ST_SQRT)
    else $error("square root finished outside its wait state");

  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_res.done |-> state_r == ST_CORD)
    else $error("CORDIC finished outside its wait state");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !out_free) |=> state_r == ST_FIN && $stable(avg_r))
    else $error("result lost while output register full");

endmodule
`default_nettype wire
